### hw/rtl/assert_macros.svh
// assertion macros for the rtl files that carry checks
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

### hw/rtl/rdsd_pkg.sv
// shared types and constants for the relay duty sigma-delta modulator
// no dependencies
`default_nettype none

package rdsd_pkg;

  // fixed field widths
  localparam int POWER_W     = 13;
  localparam int ELAPSED_W   = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int TIME_W      = 32;

  // default sizing
  localparam int POWER_FRAC_BITS_DEF = 12;
  localparam int ACC_WIDTH_DEF       = 48;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DWELL = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW    = 8'd1;

  // register reset values
  localparam logic [CFG_W-1:0] MIN_DWELL_RST = 16'd1000;
  localparam logic [CFG_W-1:0] WINDOW_RST    = 16'd10000;

  typedef struct packed {
    logic [CFG_W-1:0] dwell_floor;
    logic [CFG_W-1:0] window_len;
  } cfg_t;

  typedef struct packed {
    logic was_enabled;
    logic relay_state;
  } stat_t;

endpackage

`default_nettype wire

### hw/rtl/rdsd_cfg.sv
// configuration registers: min dwell and window length
// depends on rdsd_pkg
`default_nettype none

module rdsd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [rdsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rdsd_pkg::CFG_W-1:0]       cfg_data,
  output rdsd_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dwell_floor <= rdsd_pkg::MIN_DWELL_RST;
      cfg.window_len  <= rdsd_pkg::WINDOW_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rdsd_pkg::REG_MIN_DWELL: cfg.dwell_floor <= cfg_data;
        rdsd_pkg::REG_WINDOW:    cfg.window_len  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rdsd_prep.sv
// input register stage: power clamp, rate products and dwell threshold
// depends on rdsd_pkg
`default_nettype none

module rdsd_prep #(
  parameter int POWER_FRAC_BITS = rdsd_pkg::POWER_FRAC_BITS_DEF,
  localparam int PW = POWER_FRAC_BITS + 1,
  localparam int MW = POWER_FRAC_BITS + 17
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rdsd_pkg::cfg_t                 cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           enable,
  input  wire logic [rdsd_pkg::POWER_W-1:0]   power,
  input  wire logic [rdsd_pkg::ELAPSED_W-1:0] elapsed_ms,
  input  wire logic                           core_ready,
  output logic                                s1_valid,
  output logic                                s1_en,
  output logic [rdsd_pkg::ELAPSED_W-1:0]      s1_el,
  output logic [MW-1:0]                       s1_pel,
  output logic [MW-1:0]                       s1_oel,
  output logic [rdsd_pkg::CFG_W-1:0]          s1_dwell
);

  localparam int CW = (PW > rdsd_pkg::POWER_W) ? PW : rdsd_pkg::POWER_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << POWER_FRAC_BITS;
  localparam logic [PW-1:0] ONE_P = PW'(1) << POWER_FRAC_BITS;
  localparam int SFW = rdsd_pkg::CFG_W + POWER_FRAC_BITS;

  logic [CW-1:0]                      p_ext;
  logic [PW-1:0]                      psat;
  logic [PW-1:0]                      one_minus;
  logic [POWER_FRAC_BITS-1:0]         lesser;
  logic [MW-1:0]                      prod;
  logic [SFW-1:0]                     scaled_full;
  logic [rdsd_pkg::CFG_W-1:0]         scaled;
  logic [rdsd_pkg::CFG_W-1:0]         dwell;
  logic                               accept;

  assign in_ready = !s1_valid || core_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    p_ext     = CW'(power);
    psat      = (p_ext > ONE_C) ? ONE_P : p_ext[PW-1:0];
    one_minus = ONE_P - psat;
    // at most half of full scale, so it fits the fraction bits
    lesser    = (psat < one_minus) ? psat[POWER_FRAC_BITS-1:0]
                                   : one_minus[POWER_FRAC_BITS-1:0];
    prod        = MW'(psat) * MW'(elapsed_ms);
    scaled_full = SFW'(cfg.window_len) * SFW'(lesser);
    scaled      = scaled_full[SFW-1:POWER_FRAC_BITS];
    dwell       = (scaled > cfg.dwell_floor) ? scaled : cfg.dwell_floor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_en    <= enable;
      s1_el    <= elapsed_ms;
      s1_pel   <= {prod[MW-2:0], 1'b0};
      s1_oel   <= {elapsed_ms, {(POWER_FRAC_BITS + 1){1'b0}}};
      s1_dwell <= dwell;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rdsd_core.sv
// modulator state, saturating accumulate, dwell check and result register
// depends on rdsd_pkg
`default_nettype none

module rdsd_core #(
  parameter int POWER_FRAC_BITS = rdsd_pkg::POWER_FRAC_BITS_DEF,
  parameter int ACC_WIDTH       = rdsd_pkg::ACC_WIDTH_DEF,
  localparam int MW = POWER_FRAC_BITS + 17
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s1_valid,
  input  wire logic                           s1_en,
  input  wire logic [rdsd_pkg::ELAPSED_W-1:0] s1_el,
  input  wire logic [MW-1:0]                  s1_pel,
  input  wire logic [MW-1:0]                  s1_oel,
  input  wire logic [rdsd_pkg::CFG_W-1:0]     s1_dwell,
  output logic                                core_ready,
  output logic                                core_adv,
  output rdsd_pkg::stat_t                     stat,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                relay_on,
  output logic                                switched
);

  localparam int DW = MW + 1;
  localparam int SW = ((ACC_WIDTH > DW) ? ACC_WIDTH : DW) + 1;
  localparam int TW = rdsd_pkg::TIME_W;
  localparam logic [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH - 1){1'b0}}};

  logic                  was_enabled;
  logic                  relay_state;
  logic [ACC_WIDTH-1:0]  acc;
  logic [TW-1:0]         tis;

  logic                  was_enabled_next;
  logic                  relay_state_next;
  logic [ACC_WIDTH-1:0]  acc_next;
  logic [TW-1:0]         tis_next;

  logic [DW-1:0]         delta;
  logic [SW-1:0]         sum;
  logic [SW-ACC_WIDTH:0] sum_top;
  logic [ACC_WIDTH-1:0]  acc_sat;
  logic [TW:0]           t_sum;
  logic [TW-1:0]         t_sat;
  logic                  want_off;
  logic                  want_on;

  assign core_ready = !out_valid || out_ready;
  assign core_adv   = s1_valid && core_ready;
  assign stat       = '{was_enabled: was_enabled, relay_state: relay_state};

  always_comb begin
    delta = relay_state ? ({1'b0, s1_oel} - {1'b0, s1_pel}) : -{1'b0, s1_pel};
    sum   = {{(SW - ACC_WIDTH){acc[ACC_WIDTH-1]}}, acc}
          + {{(SW - DW){delta[DW-1]}}, delta};
    sum_top = sum[SW-1:ACC_WIDTH-1];
    if ((&sum_top) || !(|sum_top)) begin
      acc_sat = sum[ACC_WIDTH-1:0];
    end else begin
      acc_sat = sum[SW-1] ? ACC_LO : ACC_HI;
    end

    t_sum = {1'b0, tis} + (TW + 1)'(s1_el);
    t_sat = t_sum[TW] ? {TW{1'b1}} : t_sum[TW-1:0];

    want_off = relay_state && !acc_sat[ACC_WIDTH-1] && (|acc_sat);
    want_on  = !relay_state && acc_sat[ACC_WIDTH-1];

    was_enabled_next = 1'b1;
    relay_state_next = relay_state;
    acc_next         = acc_sat;
    tis_next         = t_sat;
    if (!s1_en || !was_enabled) begin
      // disabled tick or first enabled tick: clear, relay off
      was_enabled_next = s1_en;
      relay_state_next = 1'b0;
      acc_next         = '0;
      tis_next         = '0;
    end else if ((want_off || want_on) && (t_sat >= TW'(s1_dwell))) begin
      relay_state_next = want_on;
      tis_next         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_enabled <= 1'b0;
      relay_state <= 1'b0;
      acc         <= '0;
      tis         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (core_ready) begin
        out_valid <= s1_valid;
      end
      if (core_adv) begin
        was_enabled <= was_enabled_next;
        relay_state <= relay_state_next;
        acc         <= acc_next;
        tis         <= tis_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (core_adv) begin
      relay_on <= relay_state_next;
      switched <= relay_state_next != relay_state;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/relay_duty_sigma_delta_dwell.sv
// top level of the relay duty sigma-delta modulator with minimum dwell
// depends on rdsd_pkg, rdsd_cfg, rdsd_prep, rdsd_core and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Relay time-proportioning modulator. Each input transfer is one tick with an
// enable, a Q(POWER_FRAC_BITS) power demand and the milliseconds since the last
// tick; each tick yields exactly one result transfer with the relay drive and a
// switched flag. Throughput is one tick per clock while out_ready is high: the
// state (accumulator, time in state, relay, enable history) updates whenever
// the core stage advances, so ticks can stream back to back. The tick is
// registered in the input stage and its result in the core stage: the input
// register stage clamps power, forms the rate products and the dwell
// threshold (the two multipliers sit here), and the core stage does the
// saturating accumulate, the dwell compare and loads the result register. A
// finished result may wait on out_ready while the next tick is already held
// in the input stage. Configuration (min dwell, window) is written through a
// plain write port, indexes beyond the register list are ignored, and writes
// are expected only while no tick is in flight.

module relay_duty_sigma_delta_dwell #(
  parameter int POWER_FRAC_BITS = rdsd_pkg::POWER_FRAC_BITS_DEF,
  parameter int ACC_WIDTH       = rdsd_pkg::ACC_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_write,
  input  wire logic [rdsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rdsd_pkg::CFG_W-1:0]       cfg_data,
  // tick input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             enable,
  input  wire logic [rdsd_pkg::POWER_W-1:0]     power,
  input  wire logic [rdsd_pkg::ELAPSED_W-1:0]   elapsed_ms,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  relay_on,
  output logic                                  switched
);

  localparam int MW = POWER_FRAC_BITS + 17;

  rdsd_pkg::cfg_t                  cfg;
  rdsd_pkg::stat_t                 stat;

  // input stage to core
  logic                            s1_valid;
  logic                            s1_en;
  logic [rdsd_pkg::ELAPSED_W-1:0]  s1_el;
  logic [MW-1:0]                   s1_pel;   // 2*clamped power*elapsed
  logic [MW-1:0]                   s1_oel;   // 2*one*elapsed
  logic [rdsd_pkg::CFG_W-1:0]      s1_dwell; // dwell threshold for this tick
  logic                            core_ready;
  logic                            core_adv;

  rdsd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rdsd_prep #(
    .POWER_FRAC_BITS (POWER_FRAC_BITS)
  ) u_prep (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .enable     (enable),
    .power      (power),
    .elapsed_ms (elapsed_ms),
    .core_ready (core_ready),
    .s1_valid   (s1_valid),
    .s1_en      (s1_en),
    .s1_el      (s1_el),
    .s1_pel     (s1_pel),
    .s1_oel     (s1_oel),
    .s1_dwell   (s1_dwell)
  );

  rdsd_core #(
    .POWER_FRAC_BITS (POWER_FRAC_BITS),
    .ACC_WIDTH       (ACC_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_en      (s1_en),
    .s1_el      (s1_el),
    .s1_pel     (s1_pel),
    .s1_oel     (s1_oel),
    .s1_dwell   (s1_dwell),
    .core_ready (core_ready),
    .core_adv   (core_adv),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .relay_on   (relay_on),
    .switched   (switched)
  );

  // a tick held in the input stage is never dropped while the core stalls
  `ASSERT_NEXT(a_hold_stalled, clk, rst, s1_valid && !core_ready, s1_valid)
  // the delivered relay drive always matches the state the tick left behind
  `ASSERT_NEXT(a_result_tracks_state, clk, rst, core_adv,
               out_valid && (relay_on == stat.relay_state))
  // the relay is never on unless the modulator has been running
  `ASSERT_IMPL(a_off_when_idle, clk, rst, !stat.was_enabled, !stat.relay_state)

endmodule

`default_nettype wire
